// ----- design/bawm_pkg.sv -----
// Shared types, constants and helper functions of the balance and walk motor controller.
`default_nettype none

package bawm_pkg;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_BAL_P = 3'd0;
    localparam cfg_idx_t REG_BAL_D = 3'd1;
    localparam cfg_idx_t REG_SPD_P = 3'd2;
    localparam cfg_idx_t REG_SPD_I = 3'd3;
    localparam cfg_idx_t REG_LIMIT = 3'd4;

    localparam logic [12:0] LIMIT_RESET = 13'd7000;
    localparam logic [12:0] DRIVE_MAX   = 13'd7200;

    localparam logic signed [19:0] INTEG_BOUND = 20'sd384000;
    localparam logic signed [16:0] FILT_KEEP   = 17'sd179;
    localparam logic signed [16:0] FILT_NEW    = 17'sd77;

    localparam int ACC_W   = 44;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Accumulator operations and operand selects of the shared unit
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    localparam logic [1:0] SEL_P   = 2'd0;
    localparam logic [1:0] SEL_P8  = 2'd1;
    localparam logic [1:0] SEL_EXT = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] sel;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [15:0] bal_p;
        logic signed [15:0] bal_d;
        logic signed [15:0] spd_p;
        logic signed [15:0] spd_i;
        logic [12:0]        limit;
    } cfg_t;

    // Divide by 2^16, rounding toward zero.
    function automatic logic signed [27:0] trunc16(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] shifted;
        biased  = x[ACC_W-1] ? (x + ACC_W'(65535)) : x;
        shifted = biased >>> 16;
        return shifted[27:0];
    endfunction

    // Symmetric saturation at the given bound.
    function automatic logic signed [13:0] sat_drive(input logic signed [27:0] x,
                                                     input logic [12:0] lim);
        logic signed [27:0] hi;
        logic signed [27:0] lo;
        logic signed [13:0] res;
        hi = $signed({15'd0, lim});
        lo = -hi;
        if (x > hi) begin
            res = hi[13:0];
        end else if (x < lo) begin
            res = lo[13:0];
        end else begin
            res = x[13:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/bawm_cfg.sv -----
// Configuration register file of the balance and walk motor controller.
`default_nettype none

module bawm_cfg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire bawm_pkg::cfg_idx_t cfg_index,
    input  wire logic [15:0]        cfg_data,
    output bawm_pkg::cfg_t          cfg,
    output logic [12:0]             lim
);

    bawm_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    // Any bound above the motor maximum acts as the maximum.
    assign lim = (cfg_reg.limit > bawm_pkg::DRIVE_MAX) ? bawm_pkg::DRIVE_MAX : cfg_reg.limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bal_p <= '0;
            cfg_reg.bal_d <= '0;
            cfg_reg.spd_p <= '0;
            cfg_reg.spd_i <= '0;
            cfg_reg.limit <= bawm_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bawm_pkg::REG_BAL_P: cfg_reg.bal_p <= cfg_data;
                bawm_pkg::REG_BAL_D: cfg_reg.bal_d <= cfg_data;
                bawm_pkg::REG_SPD_P: cfg_reg.spd_p <= cfg_data;
                bawm_pkg::REG_SPD_I: cfg_reg.spd_i <= cfg_data;
                bawm_pkg::REG_LIMIT: cfg_reg.limit <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/bawm_mac.sv -----
// Shared multiply-accumulate unit: registered product followed by an accumulator.
`default_nettype none

module bawm_mac (
    input  wire logic                                clk,
    input  wire logic signed [bawm_pkg::MUL_A_W-1:0] mul_a,
    input  wire logic signed [bawm_pkg::MUL_B_W-1:0] mul_b,
    input  wire bawm_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [bawm_pkg::ACC_W-1:0]   ext,
    output logic signed [bawm_pkg::ACC_W-1:0]        acc
);

    logic signed [bawm_pkg::PROD_W-1:0] prod_reg;
    logic signed [bawm_pkg::PROD_W-1:0] prod_next;
    logic signed [bawm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bawm_pkg::ACC_W-1:0]  acc_next;
    logic signed [bawm_pkg::ACC_W-1:0]  prod_ext;
    logic signed [bawm_pkg::ACC_W-1:0]  operand;

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = bawm_pkg::ACC_W'(prod_reg);
    assign acc       = acc_reg;

    always_comb
    begin
        case (ctrl.sel)
            bawm_pkg::SEL_P:   operand = prod_ext;
            bawm_pkg::SEL_P8:  operand = prod_ext <<< 8;
            bawm_pkg::SEL_EXT: operand = ext;
            default:           operand = '0;
        endcase
        case (ctrl.op)
            bawm_pkg::ACC_LOAD: acc_next = operand;
            bawm_pkg::ACC_ADD:  acc_next = acc_reg + operand;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

// ----- design/bawm_walk.sv -----
// Incremental PI controller of the walk wheel with its clamped accumulator.
`default_nettype none

module bawm_walk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               upd,
    input  wire logic signed [15:0] walk_count,
    input  wire logic signed [15:0] walk_target,
    input  wire logic [12:0]        lim,
    output logic signed [13:0]      drive_next
);

    localparam logic signed [24:0] WALK_HI = 25'sd7200;

    logic signed [13:0] acc_reg;
    logic signed [13:0] acc_next;
    logic signed [17:0] prev_reg;
    logic signed [16:0] err;
    logic signed [24:0] err_ext;
    logic signed [24:0] prev_ext;
    logic signed [24:0] sum;

    assign err      = $signed({walk_count[15], walk_count}) - $signed({walk_target[15], walk_target});
    assign err_ext  = 25'(err);
    assign prev_ext = 25'(prev_reg);

    // acc + 15*(err - prev) + 15*err, i.e. acc + 30*err - 15*prev
    assign sum = 25'(acc_reg) + ((err_ext <<< 5) - (err_ext <<< 1))
                 - ((prev_ext <<< 4) - prev_ext);

    always_comb
    begin
        if (sum > WALK_HI)
        begin
            acc_next = WALK_HI[13:0];
        end
        else if (sum < -WALK_HI)
        begin
            acc_next = -(WALK_HI[13:0]);
        end
        else
        begin
            acc_next = sum[13:0];
        end
    end

    assign drive_next = bawm_pkg::sat_drive(28'(acc_next), lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else if (upd)
        begin
            acc_reg  <= acc_next;
            prev_reg <= 18'(err);
        end
    end

endmodule

`default_nettype wire

// ----- design/balance_and_walk_motor_control_unit.sv -----
// Top level: sequencer, speed filter state and stream ports of the motor controller.
// An accepted tick runs the sequencer from ST_PD_A to ST_OUT; the result is registered there
// once the output is free. One tick at a time: a new one is accepted only in ST_IDLE, and the
// sequencer steps the single shared multiplier through six products and seven accumulator steps.
// Reset: the filter, integral and walk state clear to zero, gains clear, the limit is 7000.
// A finished result waits in the output register while the next tick is accepted.
`default_nettype none

module balance_and_walk_motor_control_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // pitch_angle, pitch_rate, zero_angle, balance_count, walk_count, walk_target
    input  wire logic [95:0]              s_axis_tdata,
    // stopped
    input  wire logic                     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // balance_drive, walk_drive, 4 bits zero padding
    output logic [31:0]                   m_axis_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire bawm_pkg::cfg_idx_t       cfg_index,
    input  wire logic [15:0]              cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PD_A = 4'd1;
    localparam logic [3:0] ST_PD_B = 4'd2;
    localparam logic [3:0] ST_FL_A = 4'd3;
    localparam logic [3:0] ST_FL_B = 4'd4;
    localparam logic [3:0] ST_FL_C = 4'd5;
    localparam logic [3:0] ST_FL_D = 4'd6;
    localparam logic [3:0] ST_SP_A = 4'd7;
    localparam logic [3:0] ST_SP_B = 4'd8;
    localparam logic [3:0] ST_SP_C = 4'd9;
    localparam logic [3:0] ST_SUM  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    bawm_pkg::cfg_t     cfg;
    logic [12:0]        lim;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;

    logic signed [16:0] diff_reg;
    logic signed [15:0] rate_reg;
    logic signed [15:0] bcount_reg;
    logic signed [15:0] wcount_reg;
    logic signed [15:0] target_reg;
    logic               stop_reg;

    logic signed [23:0] filt_reg;
    logic signed [19:0] integ_reg;
    logic signed [19:0] integ_next;
    logic signed [24:0] integ_sum;
    logic signed [27:0] pd_reg;

    logic signed [13:0] bal_reg;
    logic signed [13:0] walk_reg;
    logic signed [13:0] walk_next;
    logic               out_valid_reg;
    logic               out_free;
    logic               finish;

    logic signed [bawm_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bawm_pkg::MUL_B_W-1:0] mul_b;
    logic signed [bawm_pkg::ACC_W-1:0]   ext;
    logic signed [bawm_pkg::ACC_W-1:0]   acc;
    bawm_pkg::mac_ctrl_t                 ctrl;

    bawm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .lim       (lim)
    );

    bawm_mac u_mac (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .ctrl  (ctrl),
        .ext   (ext),
        .acc   (acc)
    );

    bawm_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (finish),
        .walk_count  (wcount_reg),
        .walk_target (target_reg),
        .lim         (lim),
        .drive_next  (walk_next)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_OUT) && out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, walk_reg, bal_reg};

    // Integral of the freshly filtered speed, clamped to its bound.
    assign integ_sum = 25'(integ_reg) + 25'(filt_reg);

    always_comb
    begin
        if (integ_sum > 25'(bawm_pkg::INTEG_BOUND))
        begin
            integ_next = bawm_pkg::INTEG_BOUND;
        end
        else if (integ_sum < -25'(bawm_pkg::INTEG_BOUND))
        begin
            integ_next = -bawm_pkg::INTEG_BOUND;
        end
        else
        begin
            integ_next = integ_sum[19:0];
        end
    end

    // Sequencer: the multiplier is issued one step ahead of the accumulator that uses it.
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        ext        = '0;
        ctrl.op    = bawm_pkg::ACC_HOLD;
        ctrl.sel   = bawm_pkg::SEL_P;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_PD_A;
                end
            end
            ST_PD_A:
            begin
                mul_a      = 25'(cfg.bal_p);
                mul_b      = diff_reg;
                state_next = ST_PD_B;
            end
            ST_PD_B:
            begin
                mul_a      = 25'(rate_reg);
                mul_b      = 17'(cfg.bal_d);
                ctrl.op    = bawm_pkg::ACC_LOAD;
                state_next = ST_FL_A;
            end
            ST_FL_A:
            begin
                mul_a      = 25'(filt_reg);
                mul_b      = bawm_pkg::FILT_KEEP;
                ctrl.op    = bawm_pkg::ACC_ADD;
                ctrl.sel   = bawm_pkg::SEL_P8;
                state_next = ST_FL_B;
            end
            ST_FL_B:
            begin
                mul_a      = 25'(bcount_reg);
                mul_b      = bawm_pkg::FILT_NEW;
                ctrl.op    = bawm_pkg::ACC_LOAD;
                state_next = ST_FL_C;
            end
            ST_FL_C:
            begin
                ctrl.op    = bawm_pkg::ACC_ADD;
                ctrl.sel   = bawm_pkg::SEL_P8;
                state_next = ST_FL_D;
            end
            ST_FL_D:
            begin
                state_next = ST_SP_A;
            end
            ST_SP_A:
            begin
                mul_a      = 25'(filt_reg);
                mul_b      = 17'(cfg.spd_p);
                state_next = ST_SP_B;
            end
            ST_SP_B:
            begin
                mul_a      = 25'(integ_reg);
                mul_b      = 17'(cfg.spd_i);
                ctrl.op    = bawm_pkg::ACC_LOAD;
                // A stopped tick has no speed term: the extra operand is zero here.
                ctrl.sel   = stop_reg ? bawm_pkg::SEL_EXT : bawm_pkg::SEL_P;
                state_next = ST_SP_C;
            end
            ST_SP_C:
            begin
                ctrl.op    = stop_reg ? bawm_pkg::ACC_HOLD : bawm_pkg::ACC_ADD;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ext        = {pd_reg, 16'd0};
                ctrl.op    = bawm_pkg::ACC_ADD;
                ctrl.sel   = bawm_pkg::SEL_EXT;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filt_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FL_D)
            begin
                filt_reg <= acc[31:8];
            end
            if (state_reg == ST_SP_A)
            begin
                integ_reg <= stop_reg ? '0 : integ_next;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            diff_reg   <= $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                          - $signed({s_axis_tdata[47], s_axis_tdata[47:32]});
            rate_reg   <= s_axis_tdata[31:16];
            bcount_reg <= s_axis_tdata[63:48];
            wcount_reg <= s_axis_tdata[79:64];
            target_reg <= s_axis_tdata[95:80];
            stop_reg   <= s_axis_tuser;
        end
        if (state_reg == ST_FL_B)
        begin
            pd_reg <= bawm_pkg::trunc16(acc);
        end
        if (finish)
        begin
            bal_reg  <= bawm_pkg::sat_drive(bawm_pkg::trunc16(acc), lim);
            walk_reg <= walk_next;
        end
    end

    a_bal_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (bal_reg <= 14'sd7200) && (bal_reg >= -14'sd7200))
        else $error("balance drive outside the motor range");

    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= bawm_pkg::INTEG_BOUND) && (integ_reg >= -bawm_pkg::INTEG_BOUND))
        else $error("speed integral beyond its clamp");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_PD_A))
        else $error("accepted tick did not start the sequence");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (m_axis_tvalid && (state_reg == ST_IDLE)))
        else $error("finished tick did not present a result");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the balance and walk motor controller stream unit.
`default_nettype none

module tb_top;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_MAX        = 8;
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 24;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int REPORT_CAP      = 40;

    localparam longint FILTER_KEEP    = 179;
    localparam longint FILTER_NEW     = 77;
    localparam longint INTEG_LIMIT    = 1500 * 256;
    localparam longint WALK_GAIN      = 15;
    localparam longint WALK_LIMIT     = 7200;
    localparam longint DRIVE_CEILING  = 7200;
    localparam longint LIMIT_AT_RESET = 7000;

    localparam shortint S_MAX = 16'sh7FFF;
    localparam shortint S_MIN = 16'sh8000;

    // Index outside the register map; a write there must change nothing.
    localparam bawm_pkg::cfg_idx_t REG_SPARE = '1;

    typedef struct {
        shortint pitch_angle;
        shortint pitch_rate;
        shortint zero_angle;
        shortint balance_count;
        shortint walk_count;
        shortint walk_target;
        bit      stopped;
    } tick_t;

    typedef struct {
        logic [13:0] balance;
        logic [13:0] walk;
    } drive_t;

    class drive_scoreboard;
        longint gain_bal_p, gain_bal_d, gain_spd_p, gain_spd_i, drive_limit;
        longint speed_filt, speed_integ, walk_acc, walk_err_prev;
        drive_t expected_q[$];
        int     failures;
        int     checked;

        function new();
            gain_bal_p    = 0;
            gain_bal_d    = 0;
            gain_spd_p    = 0;
            gain_spd_i    = 0;
            drive_limit   = LIMIT_AT_RESET;
            speed_filt    = 0;
            speed_integ   = 0;
            walk_acc      = 0;
            walk_err_prev = 0;
            failures      = 0;
            checked       = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        task report(string msg);
            failures++;
            if (failures <= REPORT_CAP)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        function void set_register(bawm_pkg::cfg_idx_t idx, logic [15:0] value);
            case (idx)
                bawm_pkg::REG_BAL_P: gain_bal_p  = longint'($signed(value));
                bawm_pkg::REG_BAL_D: gain_bal_d  = longint'($signed(value));
                bawm_pkg::REG_SPD_P: gain_spd_p  = longint'($signed(value));
                bawm_pkg::REG_SPD_I: gain_spd_i  = longint'($signed(value));
                bawm_pkg::REG_LIMIT: drive_limit = longint'(value[12:0]);
                default: ;
            endcase
        endfunction

        function drive_t predict_drives(tick_t t);
            longint lim, pd, vel, total, bal, werr, wdrv;
            drive_t d;
            lim = (drive_limit > DRIVE_CEILING) ? DRIVE_CEILING : drive_limit;

            pd = (gain_bal_p * (longint'(t.pitch_angle) - longint'(t.zero_angle))
                  + longint'(t.pitch_rate) * gain_bal_d * 256) / 65536;

            // The arithmetic shift gives the floor that the filter needs for negative sums.
            speed_filt  = (FILTER_KEEP * speed_filt
                           + FILTER_NEW * longint'(t.balance_count) * 256) >>> 8;
            speed_integ = clip(speed_integ + speed_filt, -INTEG_LIMIT, INTEG_LIMIT);
            if (t.stopped)
            begin
                speed_integ = 0;
                vel = 0;
            end
            else
            begin
                vel = speed_filt * gain_spd_p + speed_integ * gain_spd_i;
            end
            total = pd * 65536 + vel;
            bal   = clip(total / 65536, -lim, lim);

            werr     = longint'(t.walk_count) - longint'(t.walk_target);
            walk_acc = clip(walk_acc + WALK_GAIN * (werr - walk_err_prev) + WALK_GAIN * werr,
                            -WALK_LIMIT, WALK_LIMIT);
            walk_err_prev = werr;
            wdrv = clip(walk_acc, -lim, lim);

            d.balance = bal[13:0];
            d.walk    = wdrv[13:0];
            return d;
        endfunction

        function void note_tick(tick_t t);
            expected_q.push_back(predict_drives(t));
        endfunction

        task check_drive(logic [13:0] bal, logic [13:0] walk);
            drive_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no tick outstanding: balance %0d walk %0d",
                                 $signed(bal), $signed(walk)));
            end
            else
            begin
                e = expected_q.pop_front();
                checked++;
                if (bal !== e.balance)
                begin
                    report($sformatf("result %0d balance_drive %0d, predicted %0d",
                                     checked, $signed(bal), $signed(e.balance)));
                end
                if (walk !== e.walk)
                begin
                    report($sformatf("result %0d walk_drive %0d, predicted %0d",
                                     checked, $signed(walk), $signed(e.walk)));
                end
            end
        endtask

        task report_leftover();
            if (expected_q.size() != 0)
            begin
                report($sformatf("%0d predicted results never arrived", expected_q.size()));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    bawm_pkg::cfg_idx_t cfg_index;
    logic [15:0] cfg_data;

    drive_scoreboard sb;
    int src_idle_max;
    int snk_idle_max;
    int ticks_sent;
    int stops_sent;
    int loads_done;

    balance_and_walk_motor_control_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly moderate values, with a full-range word now and then.
    function automatic shortint pick(int span);
        if ($urandom_range(0, 3) == 0)
        begin
            return shortint'($urandom);
        end
        return shortint'(spread(span));
    endfunction

    function automatic logic [15:0] pick_gain(int style);
        case (style)
            4:       return 16'($urandom);
            5:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'(spread(2048));
        endcase
    endfunction

    // The upper three bits of the word are outside the limit field and are randomised too.
    function automatic logic [15:0] pick_limit();
        logic [12:0] lim;
        case ($urandom_range(0, 5))
            0:       lim = 13'd0;
            1:       lim = 13'd7200;
            2:       lim = 13'h1FFF;
            3:       lim = 13'($urandom_range(0, 8191));
            default: lim = 13'($urandom_range(0, 7200));
        endcase
        return {3'($urandom), lim};
    endfunction

    function automatic tick_t make_tick(int angle, int rate, int zero, int bcount,
                                        int wcount, int target, bit stop);
        tick_t t;
        t.pitch_angle   = shortint'(angle);
        t.pitch_rate    = shortint'(rate);
        t.zero_angle    = shortint'(zero);
        t.balance_count = shortint'(bcount);
        t.walk_count    = shortint'(wcount);
        t.walk_target   = shortint'(target);
        t.stopped       = stop;
        return t;
    endfunction

    // A steady wheel speed with noise lets the filter settle and the integral reach its clamp.
    function automatic tick_t random_tick(int trend, int walk_aim);
        tick_t t;
        t.pitch_angle = pick(8192);
        t.zero_angle  = pick(1024);
        t.pitch_rate  = pick(2000);
        if ($urandom_range(0, 9) == 0)
        begin
            t.balance_count = shortint'($urandom);
        end
        else
        begin
            t.balance_count = shortint'(trend + spread(16));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            t.walk_target = shortint'($urandom);
        end
        else
        begin
            t.walk_target = shortint'(walk_aim + spread(8));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            t.walk_count = shortint'($urandom);
        end
        else
        begin
            t.walk_count = shortint'(int'(t.walk_target) + spread(60));
        end
        t.stopped = ($urandom_range(0, 9) == 0);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {t.walk_target, t.walk_count, t.balance_count,
                         t.zero_angle, t.pitch_rate, t.pitch_angle};
        s_axis_tuser  = t.stopped;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_tick(t);
        ticks_sent++;
        if (t.stopped)
        begin
            stops_sent++;
        end
        @(negedge clk);
    endtask

    task automatic write_register(input bawm_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, value);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [15:0] bal_p, input logic [15:0] bal_d,
                                 input logic [15:0] spd_p, input logic [15:0] spd_i,
                                 input logic [15:0] lim);
        write_register(bawm_pkg::REG_BAL_P, bal_p);
        write_register(bawm_pkg::REG_BAL_D, bal_d);
        write_register(bawm_pkg::REG_SPD_P, spd_p);
        write_register(bawm_pkg::REG_SPD_I, spd_i);
        write_register(bawm_pkg::REG_LIMIT, lim);
        cfg_valid = 1'b0;
        loads_done++;
    endtask

    // Every tick yields a result, so an empty store means the block is idle.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : timeout_guard
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Run timed out with %0d results still outstanding.", sb.expected_q.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, snk_idle_max);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_drive(m_axis_tdata[13:0], m_axis_tdata[27:14]);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int trend;
        int walk_aim;
        int style;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = bawm_pkg::REG_BAL_P;
        cfg_data      = '0;
        src_idle_max  = IDLE_MAX;
        snk_idle_max  = IDLE_MAX;
        ticks_sent    = 0;
        stops_sent    = 0;
        loads_done    = 0;
        trend         = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: zero gains, so only the walk path moves; large walk errors clamp.
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 1'b0));
        send_tick(make_tick(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0));
        send_tick(make_tick(S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, 1'b0));
        send_tick(make_tick(0, 0, 0, 0, S_MIN, S_MAX, 1'b1));
        drain_results();

        // Largest positive gains with a limit word above the allowed range.
        load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1FFF);
        send_tick(make_tick(S_MAX, S_MAX, S_MIN, S_MAX, 0, 0, 1'b0));
        send_tick(make_tick(S_MIN, S_MIN, S_MAX, S_MIN, 0, 0, 1'b0));
        send_tick(make_tick(S_MAX, S_MAX, S_MIN, S_MAX, 0, 0, 1'b1));
        send_tick(make_tick(0, 0, 0, S_MAX, 100, 0, 1'b0));
        send_tick(make_tick(0, 0, 0, S_MAX, 100, 0, 1'b0));
        drain_results();

        write_register(REG_SPARE, 16'hFFFF);
        cfg_valid = 1'b0;
        // Most negative gains and a zero limit, which pins both drives at zero.
        load_settings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_tick(make_tick(S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, 0, 1'b0));
        send_tick(make_tick(S_MIN, S_MAX, S_MAX, S_MAX, 0, S_MAX, 1'b1));
        drain_results();

        // Unity gains and the top limit: small values show rounding toward zero.
        load_settings(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'd7200);
        send_tick(make_tick(256, 0, 0, 1, 0, 0, 1'b0));
        send_tick(make_tick(-1, 0, 0, 0, 0, 0, 1'b0));
        send_tick(make_tick(0, -1, 0, -1, 0, 0, 1'b0));
        send_tick(make_tick(0, 1, 0, -1, 0, 0, 1'b1));
        drain_results();

        // A low limit while the walk accumulator climbs well past it.
        load_settings(16'h0100, 16'hFF00, 16'h0080, 16'hFF80, 16'd100);
        repeat (4) send_tick(make_tick(0, 0, 0, 0, 50, 0, 1'b0));
        send_tick(make_tick(0, 0, 0, 0, -50, 0, 1'b0));
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            style        = $urandom_range(0, 5);
            src_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            snk_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            load_settings(pick_gain(style), pick_gain(style), pick_gain(style),
                          pick_gain(style), pick_limit());
            walk_aim = spread(3000);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                begin
                    trend = spread(80);
                end
                send_tick(random_tick(trend, walk_aim));
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        sb.report_leftover();
        $display("Sent %0d control ticks, %0d of them with stop set, across %0d register loads.",
                 ticks_sent, stops_sent, loads_done);
        $display("Compared %0d results; %0d mismatches.", sb.checked, sb.failures);
        if (sb.failures == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
